### rtl/pnro_pkg.sv
// Package with shared types, constants and the fixed-point tables of the palette classifier.
package pnro_pkg;

  localparam int FRAC = 16;
  localparam int LABW = FRAC + 3;

  typedef logic signed [LABW-1:0] lab_comp_t;

  typedef struct packed {
    lab_comp_t l;
    lab_comp_t a;
    lab_comp_t b;
  } lab_t;

  typedef enum logic {
    REQ_WRITE    = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_t;

  typedef struct packed {
    logic [3:0]  rgb_index;
    logic [3:0]  lab_index;
    logic        differ;
    logic [17:0] rgb_dist;
    logic [35:0] lab_dist;
  } result_t;

  localparam logic [23:0] RESET_COLORS [16] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000,
    24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
    24'h808000, 24'h8080FF, 24'h800080, 24'h80FF80,
    24'h008080, 24'hFF8080, 24'h555555, 24'hAAAAAA
  };

  localparam longint M1 [9] = '{
    64'sd4122214708, 64'sd5363325363, 64'sd514459929,
    64'sd2119034982, 64'sd6806995451, 64'sd1073969566,
    64'sd883024619,  64'sd2817188376, 64'sd6299787005
  };

  localparam longint M2 [9] = '{
    64'sd2104542553,   64'sd7936177850,    -64'sd40720468,
    64'sd19779984951,  -64'sd24285922050,  64'sd4505937099,
    64'sd259040371,    64'sd7827717662,    -64'sd8086757660
  };

  function automatic logic [63:0] pow5_q30(input logic [63:0] x);
    logic [63:0] p2;
    logic [63:0] p4;
    p2 = (x * x) >> 30;
    p4 = (p2 * p2) >> 30;
    return (p4 * x) >> 30;
  endfunction

  // Elaboration-time gamma entry, used to build the constant table and the reset palette.
  function automatic logic [FRAC-1:0] gamma_entry(input int c);
    logic [63:0] lin;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] y;
    if (c * 100000 <= 1031475) begin
      lin = (64'(c) * (64'd1 << FRAC) * 64'd100 + 64'd164730) / 64'd329460;
    end else begin
      t = (64'(c * 1000 + 14025) << 30) / 64'd269025;
      r = '0;
      for (int k = 30; k >= 0; k--) begin
        cand = r | (64'd1 << k);
        if (cand <= (64'd1 << 30) && pow5_q30(cand) <= t) r = cand;
      end
      y = (((t * t) >> 30) * ((r * r) >> 30)) >> 30;
      lin = (y + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    end
    if (lin > (64'd1 << FRAC) - 64'd1) lin = (64'd1 << FRAC) - 64'd1;
    return lin[FRAC-1:0];
  endfunction

  function automatic logic [FRAC-1:0] gamma_lookup(input logic [7:0] c);
    logic [FRAC-1:0] tbl [256];
    for (int i = 0; i < 256; i++) tbl[i] = gamma_entry(i);
    return tbl[c];
  endfunction

  function automatic longint round_div10(input longint s);
    if (s >= 0) return (s + 64'sd5000000000) / 64'sd10000000000;
    return -((-s + 64'sd5000000000) / 64'sd10000000000);
  endfunction

  function automatic logic [FRAC-1:0] cube_root_c(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] c2;
    r = '0;
    for (int k = FRAC - 1; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      c2 = (cand * cand) >> FRAC;
      if (((c2 * cand) >> FRAC) <= v) r = cand;
    end
    return r[FRAC-1:0];
  endfunction

  // Elaboration-time OkLab, used only for the reset palette and the black default entry.
  function automatic lab_t to_lab_c(input logic [23:0] rgb);
    longint lin [3];
    longint lms [3];
    longint v;
    lab_t res;
    lin[0] = longint'(gamma_entry(int'(rgb[23:16])));
    lin[1] = longint'(gamma_entry(int'(rgb[15:8])));
    lin[2] = longint'(gamma_entry(int'(rgb[7:0])));
    for (int i = 0; i < 3; i++) begin
      v = round_div10(M1[3*i] * lin[0] + M1[3*i+1] * lin[1] + M1[3*i+2] * lin[2]);
      if (v < 0) v = 0;
      if (v > (64'sd1 << FRAC) - 1) v = (64'sd1 << FRAC) - 1;
      lms[i] = longint'(cube_root_c(64'(v)));
    end
    for (int i = 0; i < 3; i++) begin
      v = round_div10(M2[3*i] * lms[0] + M2[3*i+1] * lms[1] + M2[3*i+2] * lms[2]);
      if (v > (64'sd1 << (FRAC + 1)) - 1) v = (64'sd1 << (FRAC + 1)) - 1;
      if (v < -(64'sd1 << (FRAC + 1))) v = -(64'sd1 << (FRAC + 1));
      if (i == 0) res.l = v[LABW-1:0];
      else if (i == 1) res.a = v[LABW-1:0];
      else res.b = v[LABW-1:0];
    end
    return res;
  endfunction

  localparam lab_t RESET_LAB [16] = '{
    to_lab_c(RESET_COLORS[0]),  to_lab_c(RESET_COLORS[1]),
    to_lab_c(RESET_COLORS[2]),  to_lab_c(RESET_COLORS[3]),
    to_lab_c(RESET_COLORS[4]),  to_lab_c(RESET_COLORS[5]),
    to_lab_c(RESET_COLORS[6]),  to_lab_c(RESET_COLORS[7]),
    to_lab_c(RESET_COLORS[8]),  to_lab_c(RESET_COLORS[9]),
    to_lab_c(RESET_COLORS[10]), to_lab_c(RESET_COLORS[11]),
    to_lab_c(RESET_COLORS[12]), to_lab_c(RESET_COLORS[13]),
    to_lab_c(RESET_COLORS[14]), to_lab_c(RESET_COLORS[15])
  };

  localparam lab_t BLACK_LAB = to_lab_c(24'h000000);

  // Dividing by 1e10 is a shift by 10 followed by a division by 5^10. The
  // reciprocal ceil(2^66 / 5^10) gives the exact quotient for any 42-bit
  // dividend when the product is shifted right by 66.
  localparam logic [42:0] RND_RECIP = 43'd7555786372592;

  localparam longint LAB_HI = (64'sd1 <<< (FRAC + 1)) - 1;
  localparam longint LAB_LO = -(64'sd1 <<< (FRAC + 1));

  localparam logic [35:0] LAB_DIST_MAX = '1;

endpackage

### rtl/pnro_lab_unit.sv
// Sequential fixed-point sRGB to OkLab converter with a shared coefficient multiplier and a bitwise cube root.
module pnro_lab_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [23:0]   rgb,
  output logic          done,
  output pnro_pkg::lab_t lab
);
  import pnro_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LIN  = 7'b0000010,
    S_MAC1 = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_CBRT = 7'b0010000,
    S_MAC2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic [FRAC-1:0] lin [3];
  logic [FRAC-1:0] lms [3];
  logic [1:0] row;
  logic [1:0] col;
  logic signed [71:0] acc;
  logic signed [71:0] prod;
  logic [4:0] bitn;
  logic [FRAC-1:0] root;
  logic [FRAC-1:0] target;
  logic [1:0] cstep;
  logic [2*FRAC-1:0] c2;
  logic [FRAC-1:0] cand;
  logic pass2;
  logic [71:0] mag;
  logic [71:0] quot;
  logic neg;
  logic [3:0] cidx;
  logic [FRAC-1:0] mul_b;
  logic signed [71:0] rv;
  logic [2*FRAC-1:0] c2_full;
  logic [41:0] dnum;
  logic [85:0] dacc;
  logic [1:0] dstep;
  logic [20:0] dpa;
  logic [21:0] dpb;
  logic [42:0] dprod;
  logic [5:0] dshift;
  lab_comp_t lab_sat;

  assign cidx = 4'(row) * 4'd3 + 4'(col);
  assign mul_b = pass2 ? lms[col] : lin[col];
  assign prod = (pass2 ? 72'(signed'(M2[cidx])) : 72'(signed'(M1[cidx])))
                * $signed({1'b0, mul_b});
  assign cand = root | (FRAC'(1) << bitn);
  assign c2_full = cand * cand;

  // Rounding division of |s| by 1e10 as a reciprocal product in four partial steps.
  assign dnum = 42'((mag + 72'd5000000000) >> 10);
  assign dpa = dstep[1] ? dnum[41:21] : dnum[20:0];
  assign dpb = dstep[0] ? 22'(RND_RECIP[42:22]) : RND_RECIP[21:0];
  assign dprod = 43'(dpa) * 43'(dpb);
  assign dshift = (dstep[1] ? 6'd21 : 6'd0) + (dstep[0] ? 6'd22 : 6'd0);
  assign quot = 72'(dacc[85:66]);
  assign rv = neg ? -$signed(quot) : $signed(quot);

  always_comb begin
    if (rv > 72'(LAB_HI)) lab_sat = LABW'(LAB_HI);
    else if (rv < 72'(LAB_LO)) lab_sat = LABW'(LAB_LO);
    else lab_sat = rv[LABW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lin[0] <= gamma_lookup(rgb[23:16]);
            lin[1] <= gamma_lookup(rgb[15:8]);
            lin[2] <= gamma_lookup(rgb[7:0]);
            row <= '0;
            col <= '0;
            acc <= '0;
            pass2 <= 1'b0;
            state <= S_MAC1;
          end
        end
        S_LIN: state <= S_MAC1;
        S_MAC1, S_MAC2: begin
          if (col == 2'd2) begin
            mag <= (acc + prod >= 0) ? 72'(acc + prod) : 72'(-(acc + prod));
            neg <= (acc + prod) < 0;
            dacc <= '0;
            dstep <= '0;
            col <= '0;
            state <= S_DIV;
          end else begin
            acc <= acc + prod;
            col <= col + 2'd1;
          end
        end
        S_DIV: begin
          dacc <= dacc + (86'(dprod) << dshift);
          dstep <= dstep + 2'd1;
          if (dstep == 2'd3) begin
            bitn <= 5'(FRAC - 1);
            root <= '0;
            cstep <= '0;
            state <= S_CBRT;
          end
        end
        S_CBRT: begin
          if (!pass2) begin
            if (cstep == 2'd0) begin
              if (neg) target <= '0;
              else if (quot > 72'((1 << FRAC) - 1)) target <= '1;
              else target <= quot[FRAC-1:0];
              cstep <= 2'd1;
            end else if (cstep == 2'd1) begin
              c2 <= c2_full >> FRAC;
              cstep <= 2'd2;
            end else begin
              if (((48'(c2) * 48'(cand)) >> FRAC) <= 48'(target)) root <= cand;
              cstep <= 2'd1;
              if (bitn == '0) begin
                lms[row] <= (((48'(c2) * 48'(cand)) >> FRAC) <= 48'(target)) ? cand : root;
                acc <= '0;
                if (row == 2'd2) begin
                  row <= '0;
                  pass2 <= 1'b1;
                  state <= S_MAC2;
                end else begin
                  row <= row + 2'd1;
                  state <= S_MAC1;
                end
              end else begin
                bitn <= bitn - 5'd1;
              end
            end
          end else begin
            unique case (row)
              2'd0: lab.l <= lab_sat;
              2'd1: lab.a <= lab_sat;
              default: lab.b <= lab_sat;
            endcase
            acc <= '0;
            if (row == 2'd2) state <= S_DONE;
            else begin
              row <= row + 2'd1;
              state <= S_MAC2;
            end
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/pnro_search.sv
// Palette memories and the sequential nearest-entry search over both metrics.
module pnro_search #(
  parameter int PALETTE_SIZE = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             wr_en,
  input  logic [3:0]       wr_index,
  input  logic [23:0]      wr_rgb,
  input  pnro_pkg::lab_t   wr_lab,
  input  logic [23:0]      px_rgb,
  input  pnro_pkg::lab_t   px_lab,
  output logic             done,
  output pnro_pkg::result_t result
);
  import pnro_pkg::*;

  localparam int IW = $clog2(PALETTE_SIZE);

  logic [23:0] mem_rgb [PALETTE_SIZE];
  lab_t        mem_lab [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] written;
  logic [23:0] rd_rgb;
  lab_t        rd_lab;
  logic        rd_written;
  logic [IW:0] addr;
  logic [IW-1:0] cur;
  logic        busy;
  logic        have;
  logic [17:0] best_sd;
  logic [2*LABW+1:0] best_od;
  logic [IW-1:0] best_s;
  logic [IW-1:0] best_o;
  logic [23:0] q_rgb;
  lab_t        q_lab;
  logic signed [8:0] dr, dg, db;
  logic signed [LABW:0] el, ea, eb;
  logic [17:0] sd;
  logic [2*LABW+1:0] od;
  logic [2*LABW+1:0] dsh;

  always_ff @(posedge clk) begin
    if (wr_en && 32'(wr_index) < PALETTE_SIZE) begin
      mem_rgb[IW'(wr_index)] <= wr_rgb;
      mem_lab[IW'(wr_index)] <= wr_lab;
    end
    rd_rgb <= mem_rgb[addr[IW-1:0]];
    rd_lab <= mem_lab[addr[IW-1:0]];
    rd_written <= written[addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) written <= '0;
    else if (wr_en && 32'(wr_index) < PALETTE_SIZE) written[IW'(wr_index)] <= 1'b1;
  end

  always_comb begin
    if (rd_written) begin
      q_rgb = rd_rgb;
      q_lab = rd_lab;
    end else if (32'(cur) < 16) begin
      q_rgb = RESET_COLORS[4'(cur)];
      q_lab = RESET_LAB[4'(cur)];
    end else begin
      q_rgb = '0;
      q_lab = BLACK_LAB;
    end
    dr = $signed({1'b0, px_rgb[23:16]}) - $signed({1'b0, q_rgb[23:16]});
    dg = $signed({1'b0, px_rgb[15:8]}) - $signed({1'b0, q_rgb[15:8]});
    db = $signed({1'b0, px_rgb[7:0]}) - $signed({1'b0, q_rgb[7:0]});
    sd = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
    el = $signed({px_lab.l[LABW-1], px_lab.l}) - $signed({q_lab.l[LABW-1], q_lab.l});
    ea = $signed({px_lab.a[LABW-1], px_lab.a}) - $signed({q_lab.a[LABW-1], q_lab.a});
    eb = $signed({px_lab.b[LABW-1], px_lab.b}) - $signed({q_lab.b[LABW-1], q_lab.b});
    od = (2*LABW+2)'(el * el) + (2*LABW+2)'(ea * ea) + (2*LABW+2)'(eb * eb);
    dsh = best_od >> (2 * FRAC - 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      have <= 1'b0;
      done <= 1'b0;
      addr <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        have <= 1'b0;
        addr <= '0;
      end else if (busy) begin
        if (have) begin
          if (cur == '0 || sd < best_sd) begin
            best_sd <= sd;
            best_s <= cur;
          end
          if (cur == '0 || od < best_od) begin
            best_od <= od;
            best_o <= cur;
          end
        end
        if (have && 32'(cur) == PALETTE_SIZE - 1) begin
          busy <= 1'b0;
          have <= 1'b0;
        end else if (32'(addr) < PALETTE_SIZE) begin
          cur <= addr[IW-1:0];
          have <= 1'b1;
          addr <= addr + (IW+1)'(1);
        end
        if (have && 32'(cur) == PALETTE_SIZE - 1) done <= 1'b1;
      end
    end
  end

  always_comb begin
    result.rgb_index = 4'(best_s);
    result.lab_index = 4'(best_o);
    result.differ = best_s != best_o;
    result.rgb_dist = best_sd;
    result.lab_dist = (dsh > (2*LABW+2)'(LAB_DIST_MAX)) ? LAB_DIST_MAX : dsh[35:0];
  end

endmodule

### rtl/palette_nearest_rgb_oklab_unit.sv
// Top level of the palette classifier: stream handshake, sequencing and output register.
//
// Input words carry a request: req_type 0 writes entry entry_index with color_value,
// req_type 1 classifies the pixel color_value against the whole palette.
// Every word yields exactly one output word; writes return all zeros.
// An input word is taken when s_tvalid and s_tready are high; one word is
// processed at a time. The OkLab conversion runs on one shared coefficient
// multiplier, a four-step reciprocal divide and a 16-step bitwise cube-root
// search per component, dominated by the cube roots. A write's output word is
// valid once the conversion is done; a classify then scans the palette memory
// at one entry per cycle before its output word is valid.
// The result sits in an output register; a stalled m_tready holds it and the
// block can take the next input word in the cycle after the output word is taken.
// Reset (rst, synchronous) restores the sixteen default colors without a
// clearing pass, using per-entry written flags.
module palette_nearest_rgb_oklab_unit #(
  parameter int PALETTE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_index[3:0], color_value[27:4], zero pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // rgb idx[3:0], lab idx[7:4], differ[8],
                                 // rgb dist[26:9], lab dist[62:27], zero pad
);
  import pnro_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_LAB  = 4'b0010,
    T_SRCH = 4'b0100,
    T_OUT  = 4'b1000
  } tstate_t;

  tstate_t state;
  req_t req;
  logic [3:0] idx;
  logic [23:0] color;
  logic lab_start, lab_done, srch_start, srch_done, wr_en;
  lab_t lab;
  result_t res;

  assign s_tready = state == T_IDLE && !m_tvalid;
  assign wr_en = lab_done && req == REQ_WRITE;

  pnro_lab_unit u_lab (
    .clk(clk), .rst(rst), .start(lab_start), .rgb(color), .done(lab_done), .lab(lab)
  );

  pnro_search #(.PALETTE_SIZE(PALETTE_SIZE)) u_srch (
    .clk(clk), .rst(rst), .start(srch_start), .wr_en(wr_en), .wr_index(idx),
    .wr_rgb(color), .wr_lab(lab), .px_rgb(color), .px_lab(lab),
    .done(srch_done), .result(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      m_tvalid <= 1'b0;
      lab_start <= 1'b0;
      srch_start <= 1'b0;
    end else begin
      lab_start <= 1'b0;
      srch_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        T_IDLE: if (s_tvalid && s_tready) begin
          req <= req_t'(s_tuser);
          idx <= s_tdata[3:0];
          color <= s_tdata[27:4];
          lab_start <= 1'b1;
          state <= T_LAB;
        end
        T_LAB: if (lab_done) begin
          if (req == REQ_WRITE) begin
            m_tdata <= '0;
            m_tvalid <= 1'b1;
            state <= T_IDLE;
          end else begin
            srch_start <= 1'b1;
            state <= T_SRCH;
          end
        end
        T_SRCH: if (srch_done) state <= T_OUT;
        T_OUT: begin
          m_tdata <= {1'b0, res.lab_dist, res.rgb_dist, res.differ, res.lab_index,
                      res.rgb_index};
          m_tvalid <= 1'b1;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

### tb/palette_nearest_rgb_oklab_unit_test.sv
// Palette classifier testbench: directed and random palette writes and pixel queries checked by a predictor.
`timescale 1ns / 100ps

module palette_nearest_rgb_oklab_unit_test;
  import pnro_pkg::*;

  localparam int NCOL = 16;
  localparam int FQ = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    req_t        kind;
    logic [3:0]  index;
    logic [23:0] color;
  } request_t;

  typedef struct {
    longint l;
    longint a;
    longint b;
  } lab_val_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;

  request_t    pending_words[$];
  result_t     expected_results[$];
  logic [23:0] shadow_rgb[NCOL];
  lab_val_t    shadow_lab[NCOL];
  longint      lin_table[256];
  int          errors;
  int          send_idle;
  int          recv_stall;
  int          quiet_cycles;

  palette_nearest_rgb_oklab_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic longint fifth_power(longint x);
    longint p2;
    longint p4;
    p2 = (x * x) >>> 30;
    p4 = (p2 * p2) >>> 30;
    return (p4 * x) >>> 30;
  endfunction

  function automatic longint linearize(int c);
    longint lin;
    longint t;
    longint r;
    longint cand;
    longint y;
    if (c * 100000 <= 1031475) begin
      lin = (longint'(c) * (64'sd1 <<< FQ) * 100 + 164730) / 329460;
    end else begin
      t = (longint'(c * 1000 + 14025) <<< 30) / 269025;
      r = 0;
      for (int k = 30; k >= 0; k--) begin
        cand = r | (64'sd1 <<< k);
        if (cand <= (64'sd1 <<< 30) && fifth_power(cand) <= t) r = cand;
      end
      y = (((t * t) >>> 30) * ((r * r) >>> 30)) >>> 30;
      lin = (y + (64'sd1 <<< (29 - FQ))) >>> (30 - FQ);
    end
    if (lin > (64'sd1 <<< FQ) - 1) lin = (64'sd1 <<< FQ) - 1;
    return lin;
  endfunction

  function automatic longint scale_round(longint s);
    if (s >= 0) return (s + 64'sd5000000000) / 64'sd10000000000;
    return -((-s + 64'sd5000000000) / 64'sd10000000000);
  endfunction

  function automatic longint cbrt_floor(longint v);
    longint r;
    longint cand;
    longint c2;
    r = 0;
    for (int k = FQ - 1; k >= 0; k--) begin
      cand = r | (64'sd1 <<< k);
      c2 = (cand * cand) >>> FQ;
      if (((c2 * cand) >>> FQ) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic lab_val_t pixel_lab(logic [23:0] rgb);
    longint lin[3];
    longint cone[3];
    longint o[3];
    longint v;
    lab_val_t res;
    lin[0] = lin_table[rgb[23:16]];
    lin[1] = lin_table[rgb[15:8]];
    lin[2] = lin_table[rgb[7:0]];
    for (int i = 0; i < 3; i++) begin
      v = scale_round(M1[3*i] * lin[0] + M1[3*i+1] * lin[1] + M1[3*i+2] * lin[2]);
      if (v < 0) v = 0;
      if (v > (64'sd1 <<< FQ) - 1) v = (64'sd1 <<< FQ) - 1;
      cone[i] = cbrt_floor(v);
    end
    for (int i = 0; i < 3; i++) begin
      v = scale_round(M2[3*i] * cone[0] + M2[3*i+1] * cone[1] + M2[3*i+2] * cone[2]);
      if (v > (64'sd1 <<< (FQ + 1)) - 1) v = (64'sd1 <<< (FQ + 1)) - 1;
      if (v < -(64'sd1 <<< (FQ + 1))) v = -(64'sd1 <<< (FQ + 1));
      o[i] = v;
    end
    res.l = o[0];
    res.a = o[1];
    res.b = o[2];
    return res;
  endfunction

  function automatic result_t classify_or_write(request_t rq);
    result_t res;
    lab_val_t p;
    longint dr, dg, db, sd, od, best_sd, best_od;
    int best_s, best_o;
    res = '0;
    if (rq.kind == REQ_WRITE) begin
      shadow_rgb[rq.index] = rq.color;
      shadow_lab[rq.index] = pixel_lab(rq.color);
      return res;
    end
    p = pixel_lab(rq.color);
    best_s = 0;
    best_o = 0;
    best_sd = 0;
    best_od = 0;
    for (int i = 0; i < NCOL; i++) begin
      dr = longint'(rq.color[23:16]) - longint'(shadow_rgb[i][23:16]);
      dg = longint'(rq.color[15:8]) - longint'(shadow_rgb[i][15:8]);
      db = longint'(rq.color[7:0]) - longint'(shadow_rgb[i][7:0]);
      sd = dr * dr + dg * dg + db * db;
      od = (p.l - shadow_lab[i].l) ** 2 + (p.a - shadow_lab[i].a) ** 2
         + (p.b - shadow_lab[i].b) ** 2;
      if (i == 0 || sd < best_sd) begin
        best_sd = sd;
        best_s = i;
      end
      if (i == 0 || od < best_od) begin
        best_od = od;
        best_o = i;
      end
    end
    if (best_od > 64'sd68719476735) best_od = 64'sd68719476735;
    res.rgb_index = best_s[3:0];
    res.lab_index = best_o[3:0];
    res.differ = (best_s != best_o);
    res.rgb_dist = best_sd[17:0];
    res.lab_dist = best_od[35:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [23:0] random_color();
    case ($urandom_range(0, 3))
      0: return RESET_COLORS[$urandom_range(0, 15)];
      1: return RESET_COLORS[$urandom_range(0, 15)] ^ 24'($urandom_range(0, 7) * 24'h010101);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_word(req_t k, int idx, logic [23:0] c);
    request_t rq;
    rq.kind = k;
    rq.index = idx[3:0];
    rq.color = c;
    pending_words.push_back(rq);
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        s_tvalid <= 1;
        s_tuser <= pending_words[0].kind;
        s_tdata <= {4'b0, pending_words[0].color, pending_words[0].index};
        expected_results.push_back(classify_or_write(pending_words.pop_front()));
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rgb_index = m_tdata[3:0];
        got.lab_index = m_tdata[7:4];
        got.differ = m_tdata[8];
        got.rgb_dist = m_tdata[26:9];
        got.lab_dist = m_tdata[62:27];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", got.rgb_index, -1);
        end else begin
          want = expected_results.pop_front();
          if (got.rgb_index != want.rgb_index)
            report_mismatch("rgb index", got.rgb_index, want.rgb_index);
          if (got.lab_index != want.lab_index)
            report_mismatch("lab index", got.lab_index, want.lab_index);
          if (got.differ != want.differ)
            report_mismatch("differ flag", got.differ, want.differ);
          if (got.rgb_dist != want.rgb_dist)
            report_mismatch("rgb distance", got.rgb_dist, want.rgb_dist);
          if (got.lab_dist != want.lab_dist)
            report_mismatch("lab distance", got.lab_dist, want.lab_dist);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int drain;
    errors = 0;
    send_idle = 0;
    recv_stall = 0;
    rst = 1;
    s_tvalid = 0;
    s_tuser = 0;
    s_tdata = '0;
    m_tready = 0;
    for (int c = 0; c < 256; c++) lin_table[c] = linearize(c);
    for (int i = 0; i < NCOL; i++) begin
      shadow_rgb[i] = RESET_COLORS[i];
      shadow_lab[i] = pixel_lab(RESET_COLORS[i]);
    end
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: reset palette hits, extremes, ties, then writes at both ends and a duplicated entry.
    queue_word(REQ_CLASSIFY, 0, 24'h000000);
    queue_word(REQ_CLASSIFY, 15, 24'hFFFFFF);
    queue_word(REQ_CLASSIFY, 5, 24'hAAAAAA);
    queue_word(REQ_CLASSIFY, 0, 24'h404040);
    queue_word(REQ_CLASSIFY, 0, 24'h7F7F7F);
    queue_word(REQ_CLASSIFY, 0, 24'h010203);
    queue_word(REQ_CLASSIFY, 0, 24'h0B0B0B);
    queue_word(REQ_WRITE, 0, 24'hFFFFFF);
    queue_word(REQ_WRITE, 15, 24'h000000);
    queue_word(REQ_CLASSIFY, 0, 24'hFFFFFF);
    queue_word(REQ_CLASSIFY, 0, 24'h000000);
    queue_word(REQ_WRITE, 3, 24'h123456);
    queue_word(REQ_WRITE, 4, 24'h123456);
    queue_word(REQ_CLASSIFY, 9, 24'h123456);
    queue_word(REQ_CLASSIFY, 0, 24'h0C0C0C);
    queue_word(REQ_WRITE, 10, 24'h0A0A0A);
    queue_word(REQ_CLASSIFY, 0, 24'h0A0B0A);

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 235; n++) begin
        if ($urandom_range(0, 3) == 0) queue_word(REQ_WRITE, $urandom_range(0, 15), random_color());
        else queue_word(REQ_CLASSIFY, $urandom_range(0, 15), random_color());
      end
      wait (pending_words.size() == 0 && expected_results.size() == 0);
      @(posedge clk);
      send_idle = (phase == 0) ? 84 : (phase == 1) ? 0 : 10;
      recv_stall = (phase == 1) ? 84 : (phase == 2) ? 10 : 0;
    end
    drain = 0;
    while (drain < 2000 && (expected_results.size() != 0 || s_tvalid)) begin
      @(posedge clk);
      drain++;
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
